FILE: rtl/ubhe_pkg.sv
// ----------------------------------------------------------------------------
// ubhe_pkg
// types, codes and constants shared by the bootloader host engine
// ----------------------------------------------------------------------------
package ubhe_pkg;

	localparam int MAX_TRANSFER = 256;
	localparam int MAX_PAGES = 32;
	localparam int QDEPTH = 2;
	localparam logic [7:0] ACK_BYTE = 8'h79;
	localparam logic [7:0] ACT_BYTE = 8'h7F;
	localparam logic [7:0] CMD_READ = 8'h11;
	localparam logic [7:0] CMD_WRITE = 8'h31;
	localparam logic [7:0] CMD_ERASE = 8'h44;

	typedef enum logic [2:0] {
		ACT_ACTIVATE = 3'd0,
		ACT_READ = 3'd1,
		ACT_WRITE = 3'd2,
		ACT_ERASE = 3'd3,
		ACT_DATA = 3'd4,
		ACT_RX = 3'd5,
		ACT_TICK = 3'd6,
		ACT_NONE = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_SIZE = 2'd1,
		ST_NACK = 2'd2,
		ST_TIMEOUT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_ACT = 2'd0,
		OP_READ = 2'd1,
		OP_WRITE = 2'd2,
		OP_ERASE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ACT_ACK,
		PH_CMD_ACK,
		PH_ADDR_ACK,
		PH_RD_ACK,
		PH_RD_DATA,
		PH_WR_DATA,
		PH_FINAL_ACK
	} phase_t;

	typedef enum logic [1:0] {
		REG_ACK = 2'd0,
		REG_WRITE = 2'd1,
		REG_ERASE = 2'd2
	} reg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_EMIT,
		BK_ADDR,
		BK_ECNT,
		BK_EPAGE,
		BK_ECS
	} back_t;

	typedef struct packed {
		action_t action;
		logic [31:0] address;
		logic [8:0] length;
		logic [15:0] first_page;
		logic [5:0] page_count;
		logic [7:0] data_byte;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] tx_count;
		logic [7:0] tx_first;
		logic [7:0] tx_second;
		logic read_valid;
		logic [7:0] read_byte;
		logic want_data;
		logic done_res;
		logic [1:0] status;
		logic last;
	} out_item_t;

	typedef enum logic [1:0] {
		JOB_SINGLE,
		JOB_ADDR,
		JOB_ERASE
	} job_kind_t;

	// one job from the front part: a single result, an address frame or an erase frame
	typedef struct packed {
		job_kind_t kind;
		out_item_t single;
		logic [31:0] address;
		logic [15:0] first_page;
		logic [5:0] page_count;
	} job_t;

	typedef struct packed {
		logic cfg_valid;
		logic [1:0] cfg_index;
		logic [15:0] cfg_data;
	} cfg_t;

endpackage

FILE: rtl/ubhe_if.sv
// ----------------------------------------------------------------------------
// ubhe_in_if / ubhe_out_if / ubhe_cfg_if
// valid/ready channels of the bootloader host engine
// ----------------------------------------------------------------------------
interface ubhe_in_if import ubhe_pkg::*; ();
	logic valid;
	logic ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ubhe_out_if import ubhe_pkg::*; ();
	logic valid;
	logic ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ubhe_cfg_if ();
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [15:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

FILE: rtl/ubhe_front.sv
// ----------------------------------------------------------------------------
// ubhe_front
// accepts items, runs the protocol state and posts result jobs
// ----------------------------------------------------------------------------
module ubhe_front import ubhe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_data,
	input cfg_t cfg,
	input logic q_full,
	output logic job_valid,
	output job_t job
);

	phase_t phase_q;
	op_t op_q;
	logic [31:0] addr_q;
	logic [8:0] len_q;
	logic [8:0] left_q;
	logic [7:0] cs_q;
	logic [15:0] ticks_q;
	logic [15:0] spage_q;
	logic [5:0] pcnt_q;
	logic active_q;
	logic [15:0] tmo_ack_q, tmo_wr_q, tmo_er_q;

	phase_t phase_d;
	op_t op_d;
	logic [31:0] addr_d;
	logic [8:0] len_d, left_d;
	logic [7:0] cs_d;
	logic [15:0] ticks_d, spage_d;
	logic [5:0] pcnt_d;
	logic active_d;
	logic [15:0] limit;
	logic [7:0] m1, csn;
	logic [8:0] leftm;
	logic acc;

	assign in_ready = !q_full;
	assign acc = in_valid && in_ready;

	function automatic out_item_t mk(logic [1:0] c, logic [7:0] b0, logic [7:0] b1,
		logic rv, logic [7:0] rb, logic wd, logic dn, status_t st, logic l);
		out_item_t r;
		r.tx_count = c;
		r.tx_first = b0;
		r.tx_second = b1;
		r.read_valid = rv;
		r.read_byte = rb;
		r.want_data = wd;
		r.done_res = dn;
		r.status = st;
		r.last = l;
		return r;
	endfunction

	always_comb begin
		phase_d = phase_q;
		op_d = op_q;
		addr_d = addr_q;
		len_d = len_q;
		left_d = left_q;
		cs_d = cs_q;
		ticks_d = ticks_q;
		spage_d = spage_q;
		pcnt_d = pcnt_q;
		active_d = active_q;
		job_valid = 1'b0;
		job = '0;
		job.kind = JOB_SINGLE;
		job.address = addr_q;
		job.first_page = spage_q;
		job.page_count = pcnt_q;
		m1 = 8'(len_q - 9'd1);
		csn = cs_q ^ in_data.data_byte;
		leftm = left_q - 9'd1;
		limit = tmo_ack_q;
		if (phase_q == PH_FINAL_ACK)
			limit = (op_q == OP_ERASE) ? tmo_er_q : tmo_wr_q;
		if (acc) begin
			unique case (in_data.action)
				ACT_ACTIVATE, ACT_READ, ACT_WRITE, ACT_ERASE: begin
					if (phase_q == PH_IDLE) begin
						job_valid = 1'b1;
						ticks_d = '0;
						if (in_data.action == ACT_ACTIVATE) begin
							op_d = OP_ACT;
							phase_d = PH_ACT_ACK;
							job.single = mk(2'd1, ACT_BYTE, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0,
								ST_OK, 1'b1);
						end else if (in_data.action == ACT_ERASE) begin
							if (in_data.page_count > 6'(MAX_PAGES)) begin
								job.single = mk(2'd0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1,
									ST_SIZE, 1'b1);
							end else begin
								op_d = OP_ERASE;
								spage_d = in_data.first_page;
								pcnt_d = in_data.page_count;
								phase_d = PH_CMD_ACK;
								job.single = mk(2'd2, CMD_ERASE, ~CMD_ERASE, 1'b0, 8'h00, 1'b0,
									1'b0, ST_OK, 1'b1);
							end
						end else if (in_data.length == 9'd0) begin
							job.single = mk(2'd0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1,
								ST_OK, 1'b1);
						end else if (in_data.length > 9'(MAX_TRANSFER) ||
							(in_data.action == ACT_WRITE && in_data.length[1:0] != 2'd0)) begin
							job.single = mk(2'd0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1,
								ST_SIZE, 1'b1);
						end else begin
							op_d = (in_data.action == ACT_READ) ? OP_READ : OP_WRITE;
							addr_d = in_data.address;
							len_d = in_data.length;
							phase_d = PH_CMD_ACK;
							if (in_data.action == ACT_READ)
								job.single = mk(2'd2, CMD_READ, ~CMD_READ, 1'b0, 8'h00, 1'b0,
									1'b0, ST_OK, 1'b1);
							else
								job.single = mk(2'd2, CMD_WRITE, ~CMD_WRITE, 1'b0, 8'h00, 1'b0,
									1'b0, ST_OK, 1'b1);
						end
					end
				end
				ACT_DATA: begin
					if (phase_q == PH_WR_DATA) begin
						job_valid = 1'b1;
						cs_d = csn;
						left_d = leftm;
						if (leftm == 9'd0) begin
							phase_d = PH_FINAL_ACK;
							ticks_d = '0;
							job.single = mk(2'd2, in_data.data_byte, csn, 1'b0, 8'h00, 1'b0,
								1'b0, ST_OK, 1'b1);
						end else begin
							job.single = mk(2'd1, in_data.data_byte, 8'h00, 1'b0, 8'h00, 1'b1,
								1'b0, ST_OK, 1'b1);
						end
					end
				end
				ACT_RX: begin
					if (phase_q != PH_IDLE && phase_q != PH_WR_DATA) begin
						ticks_d = '0;
						if (phase_q == PH_RD_DATA) begin
							job_valid = 1'b1;
							left_d = leftm;
							if (leftm == 9'd0) begin
								phase_d = PH_IDLE;
								job.single = mk(2'd0, 8'h00, 8'h00, 1'b1, in_data.rx_byte, 1'b0,
									1'b1, ST_OK, 1'b1);
							end else begin
								job.single = mk(2'd0, 8'h00, 8'h00, 1'b1, in_data.rx_byte, 1'b0,
									1'b0, ST_OK, 1'b1);
							end
						end else if (in_data.rx_byte != ACK_BYTE) begin
							job_valid = 1'b1;
							phase_d = PH_IDLE;
							job.single = mk(2'd0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1,
								ST_NACK, 1'b1);
						end else begin
							unique case (phase_q)
								PH_ACT_ACK: begin
									job_valid = 1'b1;
									active_d = 1'b1;
									phase_d = PH_IDLE;
									job.single = mk(2'd0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1,
										ST_OK, 1'b1);
								end
								PH_CMD_ACK: begin
									job_valid = 1'b1;
									if (op_q == OP_ERASE) begin
										job.kind = JOB_ERASE;
										phase_d = PH_FINAL_ACK;
									end else begin
										job.kind = JOB_ADDR;
										phase_d = PH_ADDR_ACK;
									end
								end
								PH_ADDR_ACK: begin
									job_valid = 1'b1;
									if (op_q == OP_READ) begin
										job.single = mk(2'd2, m1, ~m1, 1'b0, 8'h00, 1'b0, 1'b0,
											ST_OK, 1'b1);
										phase_d = PH_RD_ACK;
									end else begin
										job.single = mk(2'd1, m1, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0,
											ST_OK, 1'b1);
										cs_d = m1;
										left_d = len_q;
										phase_d = PH_WR_DATA;
									end
								end
								PH_RD_ACK: begin
									left_d = len_q;
									phase_d = PH_RD_DATA;
								end
								PH_FINAL_ACK: begin
									job_valid = 1'b1;
									phase_d = PH_IDLE;
									job.single = mk(2'd0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1,
										ST_OK, 1'b1);
								end
								default: begin
								end
							endcase
						end
					end
				end
				ACT_TICK: begin
					if (phase_q != PH_IDLE && phase_q != PH_WR_DATA) begin
						if (ticks_q >= limit) begin
							job_valid = 1'b1;
							phase_d = PH_IDLE;
							ticks_d = '0;
							job.single = mk(2'd0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1,
								ST_TIMEOUT, 1'b1);
						end else begin
							ticks_d = ticks_q + 16'd1;
						end
					end
				end
				ACT_NONE: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			op_q <= OP_ACT;
			addr_q <= '0;
			len_q <= '0;
			left_q <= '0;
			cs_q <= '0;
			ticks_q <= '0;
			spage_q <= '0;
			pcnt_q <= '0;
			active_q <= 1'b0;
			tmo_ack_q <= 16'd10;
			tmo_wr_q <= 16'd100;
			tmo_er_q <= 16'd3000;
		end else begin
			phase_q <= phase_d;
			op_q <= op_d;
			addr_q <= addr_d;
			len_q <= len_d;
			left_q <= left_d;
			cs_q <= cs_d;
			ticks_q <= ticks_d;
			spage_q <= spage_d;
			pcnt_q <= pcnt_d;
			active_q <= active_d;
			if (cfg.cfg_valid) begin
				if (cfg.cfg_index == REG_ACK)
					tmo_ack_q <= cfg.cfg_data;
				else if (cfg.cfg_index == REG_WRITE)
					tmo_wr_q <= cfg.cfg_data;
				else if (cfg.cfg_index == REG_ERASE)
					tmo_er_q <= cfg.cfg_data;
			end
		end
	end

endmodule

FILE: rtl/ubhe_queue.sv
// ----------------------------------------------------------------------------
// ubhe_queue
// short job queue between the front and back parts
// ----------------------------------------------------------------------------
module ubhe_queue import ubhe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	input job_t wr_data,
	output logic full,
	output logic rd_valid,
	input logic rd_pop,
	output job_t rd_data
);

	localparam int AW = $clog2(QDEPTH);
	job_t mem_q [QDEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;

	assign full = cnt_q == (AW+1)'(QDEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_valid)
			mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_valid)
				wp_q <= (wp_q == AW'(QDEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (rd_pop)
				rp_q <= (rp_q == AW'(QDEPTH - 1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(wr_valid) - (AW+1)'(rd_pop);
		end
	end

endmodule

FILE: rtl/ubhe_back.sv
// ----------------------------------------------------------------------------
// ubhe_back
// expands jobs into result items: address and erase frames, a checksum byte last, the rest two bytes at a time
// ----------------------------------------------------------------------------
module ubhe_back import ubhe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	input job_t job,
	output logic job_pop,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_data
);

	back_t st_q, st_d;
	logic [31:0] addr_q;
	logic [15:0] page_q;
	logic [5:0] left_q;
	logic [7:0] cs_q;
	logic [15:0] cm1;
	logic [7:0] acs;
	out_item_t o;

	always_comb begin
		st_d = st_q;
		job_pop = 1'b0;
		out_valid = 1'b0;
		o = '0;
		o.status = ST_OK;
		cm1 = 16'({10'd0, job.page_count} - 16'd1);
		acs = addr_q[31:24] ^ addr_q[23:16] ^ addr_q[15:8] ^ addr_q[7:0];
		unique case (st_q)
			BK_IDLE: begin
				out_valid = job_valid && job.kind == JOB_SINGLE;
				o = job.single;
				if (job_valid && out_ready && job.kind == JOB_SINGLE)
					job_pop = 1'b1;
				else if (job_valid && job.kind == JOB_ADDR)
					st_d = BK_ADDR;
				else if (job_valid && job.kind == JOB_ERASE)
					st_d = BK_ECNT;
			end
			BK_ADDR: begin
				out_valid = 1'b1;
				o.tx_count = 2'd2;
				o.tx_first = addr_q[31:24];
				o.tx_second = addr_q[23:16];
				if (out_ready)
					st_d = BK_EMIT;
			end
			BK_EMIT: begin
				out_valid = 1'b1;
				o.tx_count = 2'd2;
				o.tx_first = addr_q[15:8];
				o.tx_second = addr_q[7:0];
				if (out_ready)
					st_d = BK_ECS;
			end
			BK_ECNT: begin
				out_valid = 1'b1;
				o.tx_count = 2'd2;
				o.tx_first = cm1[15:8];
				o.tx_second = cm1[7:0];
				if (out_ready)
					st_d = (left_q == '0) ? BK_ECS : BK_EPAGE;
			end
			BK_EPAGE: begin
				out_valid = 1'b1;
				o.tx_count = 2'd2;
				o.tx_first = page_q[15:8];
				o.tx_second = page_q[7:0];
				if (out_ready && left_q == 6'd1)
					st_d = BK_ECS;
			end
			BK_ECS: begin
				out_valid = 1'b1;
				o.tx_count = 2'd1;
				o.tx_first = (job.kind == JOB_ADDR) ? acs : cs_q;
				o.last = 1'b1;
				if (out_ready) begin
					st_d = BK_IDLE;
					job_pop = 1'b1;
				end
			end
			default: begin
			end
		endcase
		out_data = o;
	end

	always_ff @(posedge clk) begin
		if (st_q == BK_IDLE) begin
			addr_q <= job.address;
			page_q <= job.first_page;
			left_q <= job.page_count;
			cs_q <= cm1[15:8] ^ cm1[7:0];
		end else if (st_q == BK_EPAGE && out_ready) begin
			page_q <= page_q + 16'd1;
			left_q <= left_q - 6'd1;
			cs_q <= cs_q ^ page_q[15:8] ^ page_q[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= BK_IDLE;
		else
			st_q <= st_d;
	end

endmodule

FILE: rtl/uart_bootloader_host_engine.sv
// ----------------------------------------------------------------------------
// uart_bootloader_host_engine
// host side of a uart bootloader exchange
// ----------------------------------------------------------------------------
// The front part takes one item a cycle while its two-entry job queue has room
// and updates the protocol state at once; the back part turns each job into
// result items, one per cycle while the output is ready: a single result, an
// address frame of three items, or an erase frame of 2 + page_count items. A
// single result is written into the job queue and leaves from its head; an
// address or erase frame first moves the back part from idle into its first
// frame state and holds the back part until its checksum item is taken. Items
// that cause no result touch only the front part; configuration writes
// are taken in any cycle.
module uart_bootloader_host_engine import ubhe_pkg::*; (
	input logic clk,
	input logic arst_n,
	ubhe_in_if.sink in_ch,
	ubhe_out_if.source out_ch,
	ubhe_cfg_if.sink cfg_ch
);

	logic q_full, jv, rv, pop;
	job_t jw, jr;
	cfg_t cfg;

	assign cfg_ch.ready = 1'b1;
	assign cfg.cfg_valid = cfg_ch.valid;
	assign cfg.cfg_index = cfg_ch.index;
	assign cfg.cfg_data = cfg_ch.data;

	ubhe_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.cfg(cfg), .q_full(q_full), .job_valid(jv), .job(jw)
	);

	ubhe_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(jv), .wr_data(jw), .full(q_full),
		.rd_valid(rv), .rd_pop(pop), .rd_data(jr)
	);

	ubhe_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(rv), .job(jr), .job_pop(pop),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
	);

endmodule
